// ===== rtl/rcfd_pkg.sv =====
// rcfd_pkg: shared constants, codes and types for the serial rc frame decoder
// no dependencies; imported by every rtl module of the decoder
`default_nettype none

package rcfd_pkg;

    localparam int CHANNEL_COUNT_DEF = 14;
    localparam int FRAME_BYTES       = 32;
    localparam int CHANNEL_MAX       = 14;

    localparam logic [7:0]  HDR_FIRST   = 8'h20;
    localparam logic [7:0]  HDR_SECOND  = 8'h40;
    localparam logic [15:0] CKSUM_INIT  = 16'hFFFF;
    localparam logic [3:0]  USED_RESET  = 4'd10;

    // byte positions of the checksum word
    localparam logic [4:0]  CKSUM_LO_POS = 5'(FRAME_BYTES - 2);
    localparam logic [4:0]  CKSUM_HI_POS = 5'(FRAME_BYTES - 1);

    localparam logic STATUS_GOOD = 1'b0;
    localparam logic STATUS_BAD  = 1'b1;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'b001,
        PH_WAIT    = 3'b010,
        PH_COLLECT = 3'b100
    } phase_t;

    // one finished frame handed from front to back
    typedef struct packed {
        logic good;
        logic bank;
    } cmd_t;

    // back tells front that a word bank may be reused
    typedef struct packed {
        logic valid;
        logic bank;
    } bank_free_t;

    // back reads one word of a bank
    typedef struct packed {
        logic       bank;
        logic [3:0] idx;
    } rd_req_t;

endpackage

`default_nettype wire

// ===== rtl/rcfd_cmd_fifo.sv =====
// rcfd_cmd_fifo: two-entry queue of finished-frame words between front and back
// depends on rcfd_pkg (cmd_t)
`default_nettype none

module rcfd_cmd_fifo
    import rcfd_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr_en,
    input  wire cmd_t wr_data,
    output logic      full,
    input  wire logic rd_en,
    output cmd_t      rd_data,
    output logic      empty
);

    cmd_t       mem_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_wr;
    logic       do_rd;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_wr;
        rd_ptr_next = rd_ptr_reg ^ do_rd;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/rcfd_front.sv =====
// rcfd_front: header hunt, byte position tracking, checksum and word assembly
// into two word banks; depends on rcfd_pkg
`default_nettype none

module rcfd_front
    import rcfd_pkg::*;
#(
    parameter int CHANNEL_COUNT = CHANNEL_COUNT_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wire logic [7:0] rx_byte,
    output logic            full,
    output logic            cmd_push,
    output cmd_t            cmd,
    input  wire logic       cmd_full,
    input  wire bank_free_t free,
    input  wire rd_req_t    rd,
    output logic [15:0]     rd_word
);

    localparam int         IDX_W    = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
    localparam logic [4:0] CHAN_END = 5'(2 + 2 * CHANNEL_COUNT);

    phase_t      phase_reg;
    phase_t      phase_next;
    logic [4:0]  pos_reg;
    logic [4:0]  pos_next;
    logic [15:0] cksum_reg;
    logic [15:0] cksum_next;
    logic [7:0]  low_reg;
    logic [7:0]  low_next;
    logic        bank_reg;
    logic        bank_next;
    logic [1:0]  busy_reg;
    logic [1:0]  busy_next;

    logic [15:0] words_reg [2][CHANNEL_COUNT];

    logic             accept;
    logic             word_pos;
    logic             wr_en;
    logic             set_busy;
    logic [4:0]       pos_m2;
    logic [IDX_W-1:0] wr_idx;

    assign word_pos = (pos_reg < CHAN_END) && pos_reg[0];
    assign full     = (phase_reg == PH_COLLECT)
                   && (((pos_reg == CKSUM_HI_POS) && cmd_full)
                       || (word_pos && busy_reg[bank_reg]));
    assign accept   = push && !full;
    assign pos_m2   = pos_reg - 5'd2;
    assign wr_idx   = pos_m2[IDX_W:1];
    assign rd_word  = words_reg[rd.bank][rd.idx[IDX_W-1:0]];

    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        cksum_next = cksum_reg;
        low_next   = low_reg;
        bank_next  = bank_reg;
        wr_en      = 1'b0;
        set_busy   = 1'b0;
        cmd_push   = 1'b0;
        cmd.good   = 1'b0;
        cmd.bank   = bank_reg;
        if (accept)
        begin
            unique case (phase_reg)
                PH_WAIT:
                begin
                    if (rx_byte == HDR_SECOND)
                    begin
                        cksum_next = cksum_reg - {8'd0, rx_byte};
                        pos_next   = 5'd2;
                        phase_next = PH_COLLECT;
                    end
                end
                PH_COLLECT:
                begin
                    if (pos_reg < CKSUM_LO_POS)
                    begin
                        // bytes past the channel words are skipped
                        if (pos_reg < CHAN_END)
                        begin
                            cksum_next = cksum_reg - {8'd0, rx_byte};
                            if (!pos_reg[0])
                            begin
                                low_next = rx_byte;
                            end
                            else
                            begin
                                wr_en = 1'b1;
                            end
                        end
                        pos_next = pos_reg + 5'd1;
                    end
                    else if (pos_reg == CKSUM_LO_POS)
                    begin
                        low_next = rx_byte;
                        pos_next = CKSUM_HI_POS;
                    end
                    else
                    begin
                        cmd_push   = 1'b1;
                        cmd.good   = ({rx_byte, low_reg} == cksum_reg);
                        phase_next = PH_HUNT;
                        pos_next   = 5'd0;
                        cksum_next = CKSUM_INIT;
                        if (cmd.good)
                        begin
                            set_busy  = 1'b1;
                            bank_next = !bank_reg;
                        end
                    end
                end
                default:
                begin
                    if (rx_byte == HDR_FIRST)
                    begin
                        cksum_next = CKSUM_INIT - {8'd0, rx_byte};
                        pos_next   = 5'd1;
                        phase_next = PH_WAIT;
                    end
                    else
                    begin
                        phase_next = PH_HUNT;
                    end
                end
            endcase
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        if (free.valid)
        begin
            busy_next[free.bank] = 1'b0;
        end
        if (set_busy)
        begin
            busy_next[bank_reg] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            pos_reg   <= 5'd0;
            cksum_reg <= CKSUM_INIT;
            low_reg   <= 8'd0;
            bank_reg  <= 1'b0;
            busy_reg  <= 2'b00;
        end
        else
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            cksum_reg <= cksum_next;
            low_reg   <= low_next;
            bank_reg  <= bank_next;
            busy_reg  <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            words_reg[bank_reg][wr_idx] <= {rx_byte, low_reg};
        end
    end

endmodule

`default_nettype wire

// ===== rtl/rcfd_back.sv =====
// rcfd_back: turns queued frame words into channel or error results,
// holds used_channels and the result register; depends on rcfd_pkg
`default_nettype none

module rcfd_back
    import rcfd_pkg::*;
#(
    parameter int CHANNEL_COUNT = CHANNEL_COUNT_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [3:0]  used_channels,
    input  wire cmd_t        head,
    input  wire logic        cmd_empty,
    output logic             cmd_pop,
    output bank_free_t       free,
    output rd_req_t          rd,
    input  wire logic [15:0] rd_word,
    output logic             empty,
    input  wire logic        pop,
    output logic             frame_status,
    output logic [3:0]       channel_index,
    output logic [15:0]      channel_value,
    output logic             last
);

    localparam logic [3:0] CH_MAX = 4'(CHANNEL_COUNT);

    logic [3:0]  used_reg;
    logic [3:0]  idx_reg;
    logic [3:0]  idx_next;
    logic        valid_reg;
    logic        valid_next;
    logic        status_reg;
    logic        status_next;
    logic [3:0]  index_reg;
    logic [3:0]  index_next;
    logic [15:0] value_reg;
    logic [15:0] value_next;
    logic        last_reg;
    logic        last_next;

    logic [3:0]  n_used;
    logic        advance;
    logic        at_last;

    assign n_used  = (used_reg > CH_MAX) ? CH_MAX : used_reg;
    assign advance = !cmd_empty && (!valid_reg || pop);
    assign at_last = (idx_reg == n_used - 4'd1);
    assign rd.bank = head.bank;
    assign rd.idx  = idx_reg;

    assign empty         = !valid_reg;
    assign frame_status  = status_reg;
    assign channel_index = index_reg;
    assign channel_value = value_reg;
    assign last          = last_reg;

    always_comb
    begin
        idx_next    = idx_reg;
        valid_next  = valid_reg && !pop;
        status_next = status_reg;
        index_next  = index_reg;
        value_next  = value_reg;
        last_next   = last_reg;
        cmd_pop     = 1'b0;
        free.valid  = 1'b0;
        free.bank   = head.bank;
        if (advance)
        begin
            if (!head.good)
            begin
                valid_next  = 1'b1;
                status_next = STATUS_BAD;
                index_next  = 4'd0;
                value_next  = 16'd0;
                last_next   = 1'b1;
                cmd_pop     = 1'b1;
            end
            else if (n_used == 4'd0)
            begin
                // good frame with no channels in use: nothing to emit
                cmd_pop    = 1'b1;
                free.valid = 1'b1;
            end
            else
            begin
                valid_next  = 1'b1;
                status_next = STATUS_GOOD;
                index_next  = idx_reg;
                value_next  = rd_word;
                last_next   = at_last;
                if (at_last)
                begin
                    cmd_pop    = 1'b1;
                    free.valid = 1'b1;
                    idx_next   = 4'd0;
                end
                else
                begin
                    idx_next = idx_reg + 4'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg  <= USED_RESET;
            idx_reg   <= 4'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                used_reg <= used_channels;
            end
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        index_reg  <= index_next;
        value_reg  <= value_next;
        last_reg   <= last_next;
    end

endmodule

`default_nettype wire

// ===== rtl/rc_serial_frame_channel_decoder_unit.sv =====
// rc_serial_frame_channel_decoder_unit: top level of the serial rc frame decoder
// depends on rcfd_pkg, rcfd_front, rcfd_cmd_fifo, rcfd_back
//
//   side     handshake        payload
//   input    push / full      rx_byte[7:0]
//   result   empty / pop      frame_status, channel_index[3:0], channel_value[15:0], last
//   config   cfg_wr_en        used_channels[3:0]
//
// one byte is taken per cycle while full is low; a frame's results follow one per cycle from the result
// register while pop is held, up to used_channels words or one error word after the final checksum byte
// word storage is two banks, so the front stalls a word write only when both
// banks still wait to be emitted, and the final byte when the frame queue is full
// reset is asynchronous and immediate; no clearing pass
`default_nettype none

module rc_serial_frame_channel_decoder_unit
    import rcfd_pkg::*;
#(
    parameter int CHANNEL_COUNT = CHANNEL_COUNT_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  rx_byte,
    output logic             empty,
    input  wire logic        pop,
    output logic             frame_status,
    output logic [3:0]       channel_index,
    output logic [15:0]      channel_value,
    output logic             last,
    input  wire logic        cfg_wr_en,
    input  wire logic [3:0]  used_channels
);

    cmd_t        cmd_in;
    cmd_t        cmd_head;
    logic        cmd_push;
    logic        cmd_full;
    logic        cmd_pop;
    logic        cmd_empty;
    bank_free_t  free;
    rd_req_t     rd;
    logic [15:0] rd_word;

    rcfd_front #(
        .CHANNEL_COUNT(CHANNEL_COUNT)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .rx_byte  (rx_byte),
        .full     (full),
        .cmd_push (cmd_push),
        .cmd      (cmd_in),
        .cmd_full (cmd_full),
        .free     (free),
        .rd       (rd),
        .rd_word  (rd_word)
    );

    rcfd_cmd_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_push),
        .wr_data (cmd_in),
        .full    (cmd_full),
        .rd_en   (cmd_pop),
        .rd_data (cmd_head),
        .empty   (cmd_empty)
    );

    rcfd_back #(
        .CHANNEL_COUNT(CHANNEL_COUNT)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .used_channels (used_channels),
        .head          (cmd_head),
        .cmd_empty     (cmd_empty),
        .cmd_pop       (cmd_pop),
        .free          (free),
        .rd            (rd),
        .rd_word       (rd_word),
        .empty         (empty),
        .pop           (pop),
        .frame_status  (frame_status),
        .channel_index (channel_index),
        .channel_value (channel_value),
        .last          (last)
    );

endmodule

`default_nettype wire

// ===== verif/rc_serial_frame_channel_decoder_unit_tb.sv =====
// testbench for rc_serial_frame_channel_decoder_unit: drives serial bytes, frames and noise,
// predicts every channel word from its own frame decoder and checks each word in order
// depends on rcfd_pkg and the rtl of the decoder
`default_nettype none

module rc_serial_frame_channel_decoder_unit_tb
    import rcfd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_CH       = CHANNEL_COUNT_DEF;
    localparam int IDLE_LIMIT = 2000;
    localparam int SETTLE     = 40;
    localparam int RAND_BYTES = 160;

    typedef struct packed {
        logic        status;
        logic [3:0]  idx;
        logic [15:0] val;
        logic        lst;
    } chan_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  rx_byte = 8'h00;
    logic        empty;
    logic        pop = 1'b0;
    logic        frame_status;
    logic [3:0]  channel_index;
    logic [15:0] channel_value;
    logic        last;
    logic        cfg_wr_en = 1'b0;
    logic [3:0]  used_channels = USED_RESET;

    // decoder state as the testbench tracks it
    phase_t      sync_ph = PH_HUNT;
    logic [4:0]  byte_pos = '0;
    logic [15:0] run_sum = CKSUM_INIT;
    logic [7:0]  low_byte = '0;
    logic [15:0] rx_words [N_CH];
    logic [3:0]  used_cfg = USED_RESET;

    logic [7:0]  pending_bytes [$];
    logic [7:0]  frame_buf [$];
    logic [15:0] chan_words [N_CH];
    chan_word_t  expected_words [$];

    int in_gap_max = 0;
    int out_stall_max = 0;
    int in_wait = 0;
    int pop_wait = 0;
    int idle_cycles = 0;
    int err_cnt = 0;

    rc_serial_frame_channel_decoder_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .rx_byte       (rx_byte),
        .empty         (empty),
        .pop           (pop),
        .frame_status  (frame_status),
        .channel_index (channel_index),
        .channel_value (channel_value),
        .last          (last),
        .cfg_wr_en     (cfg_wr_en),
        .used_channels (used_channels)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    task report_error(input string msg);
        $display("%0t mismatch: %s", $time, msg);
        err_cnt++;
    endtask

    // advance the frame decoder by one byte and queue the words it releases
    task decode_byte(input logic [7:0] b);
        int n;
        int widx;
        logic good;
        chan_word_t w;
        case (sync_ph)
            PH_WAIT:
            begin
                // anything but the second header byte is dropped, a repeated first one too
                if (b == HDR_SECOND)
                begin
                    run_sum = run_sum - {8'h00, b};
                    byte_pos = 5'd2;
                    sync_ph = PH_COLLECT;
                end
            end
            PH_COLLECT:
            begin
                if (byte_pos < CKSUM_LO_POS)
                begin
                    if (int'(byte_pos) < 2 + 2 * N_CH)
                    begin
                        widx = (int'(byte_pos) - 2) >> 1;
                        run_sum = run_sum - {8'h00, b};
                        if (!byte_pos[0])
                            low_byte = b;
                        else
                            rx_words[widx] = {b, low_byte};
                    end
                    byte_pos = byte_pos + 5'd1;
                end
                else if (byte_pos == CKSUM_LO_POS)
                begin
                    low_byte = b;
                    byte_pos = byte_pos + 5'd1;
                end
                else
                begin
                    good = ({b, low_byte} == run_sum);
                    sync_ph = PH_HUNT;
                    byte_pos = '0;
                    run_sum = CKSUM_INIT;
                    if (!good)
                    begin
                        w.status = STATUS_BAD;
                        w.idx = 4'd0;
                        w.val = 16'd0;
                        w.lst = 1'b1;
                        expected_words.push_back(w);
                    end
                    else
                    begin
                        // a count above the channel total saturates, zero releases nothing
                        n = (int'(used_cfg) > N_CH) ? N_CH : int'(used_cfg);
                        for (int k = 0; k < n; k++)
                        begin
                            w.status = STATUS_GOOD;
                            w.idx = 4'(k);
                            w.val = rx_words[k];
                            w.lst = (k == n - 1);
                            expected_words.push_back(w);
                        end
                    end
                end
            end
            default:
            begin
                if (b == HDR_FIRST)
                begin
                    run_sum = CKSUM_INIT - {8'h00, b};
                    byte_pos = 5'd1;
                    sync_ph = PH_WAIT;
                end
                else
                begin
                    sync_ph = PH_HUNT;
                end
            end
        endcase
    endtask

    // byte driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
            in_wait = 0;
        end
        else
        begin
            if (push && !full)
                decode_byte(rx_byte);
            if (push && full)
            begin
                // hold the byte until it is taken
            end
            else if (in_wait > 0)
            begin
                in_wait--;
                push <= 1'b0;
            end
            else if (pending_bytes.size() != 0)
            begin
                rx_byte <= pending_bytes.pop_front();
                push <= 1'b1;
                in_wait = $urandom_range(0, in_gap_max);
            end
            else
            begin
                push <= 1'b0;
            end
        end
    end

    // channel word monitor
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
            pop_wait = 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (expected_words.size() == 0)
                begin
                    report_error($sformatf("unexpected word st=%0d idx=%0d val=%h last=%0d",
                        frame_status, channel_index, channel_value, last));
                end
                else
                begin
                    if (frame_status !== expected_words[0].status)
                        report_error($sformatf("frame_status got %0d want %0d",
                            frame_status, expected_words[0].status));
                    if (channel_index !== expected_words[0].idx)
                        report_error($sformatf("channel_index got %0d want %0d",
                            channel_index, expected_words[0].idx));
                    if (channel_value !== expected_words[0].val)
                        report_error($sformatf("channel_value got %h want %h",
                            channel_value, expected_words[0].val));
                    if (last !== expected_words[0].lst)
                        report_error($sformatf("last got %0d want %0d",
                            last, expected_words[0].lst));
                    void'(expected_words.pop_front());
                end
                pop_wait = $urandom_range(0, out_stall_max);
            end
            if (pop_wait > 0)
            begin
                pop_wait--;
                pop <= 1'b0;
            end
            else
            begin
                pop <= 1'b1;
            end
        end
    end

    // watchdog on cycles where neither side moves a byte or a word
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("[rc_serial_frame_channel_decoder_unit] ERROR");
                $finish;
            end
        end
    end

    task automatic wait_idle(input int settle);
        @(negedge clk);
        while (pending_bytes.size() != 0 || push || expected_words.size() != 0)
            @(negedge clk);
        repeat (settle) @(negedge clk);
    endtask

    task automatic set_channels(input logic [3:0] v);
        wait_idle(SETTLE);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        used_channels <= v;
        used_cfg = v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_pace();
        int r;
        r = $urandom_range(0, 3);
        in_gap_max = (r == 0) ? 0 : ((r == 1) ? 2 : 5);
        r = $urandom_range(0, 3);
        out_stall_max = (r == 0) ? 0 : ((r == 1) ? 2 : 5);
    endtask

    // mode 1 gives fixed extreme words, mode 0 random ones with some extremes
    task automatic fill_words(input int mode);
        int r;
        for (int k = 0; k < N_CH; k++)
        begin
            r = $urandom_range(0, 9);
            if (mode == 1)
                chan_words[k] = (k % 4 == 0) ? 16'h0000 : (k % 4 == 1) ? 16'hFFFF :
                                (k % 4 == 2) ? 16'h00FF : 16'hFF00;
            else if (r == 0)
                chan_words[k] = 16'h0000;
            else if (r == 1)
                chan_words[k] = 16'hFFFF;
            else
                chan_words[k] = 16'($urandom);
        end
    endtask

    // junk bytes go between the two header bytes; the first one repeats the header
    task automatic build_frame(input bit bad_sum, input int junk_len);
        logic [15:0] acc;
        logic [7:0]  jb;
        frame_buf.delete();
        frame_buf.push_back(HDR_FIRST);
        for (int j = 0; j < junk_len; j++)
        begin
            jb = 8'($urandom);
            if (j == 0 || jb == HDR_SECOND)
                jb = HDR_FIRST;
            frame_buf.push_back(jb);
        end
        frame_buf.push_back(HDR_SECOND);
        acc = CKSUM_INIT - {8'h00, HDR_FIRST} - {8'h00, HDR_SECOND};
        for (int k = 0; k < N_CH; k++)
        begin
            frame_buf.push_back(chan_words[k][7:0]);
            frame_buf.push_back(chan_words[k][15:8]);
            acc = acc - {8'h00, chan_words[k][7:0]} - {8'h00, chan_words[k][15:8]};
        end
        if (bad_sum)
            acc = acc ^ (16'h0001 << $urandom_range(0, 15));
        frame_buf.push_back(acc[7:0]);
        frame_buf.push_back(acc[15:8]);
    endtask

    task automatic queue_bytes(input int from, input int upto);
        for (int j = from; j < upto; j++)
            pending_bytes.push_back(frame_buf[j]);
    endtask

    task automatic queue_random_traffic(input int n_bytes);
        int queued;
        int r;
        int cut;
        queued = 0;
        while (queued < n_bytes)
        begin
            r = $urandom_range(0, 99);
            if (r < 88)
            begin
                fill_words(0);
                build_frame(r >= 66 && r < 76, (r >= 80) ? $urandom_range(1, 3) : 0);
                cut = frame_buf.size();
                // broken frame: cut short; zero fill ends it if cut past the second header
                if (r >= 76 && r < 80)
                    cut = $urandom_range(1, frame_buf.size() - 1);
                queue_bytes(0, cut);
                repeat (frame_buf.size() - cut) pending_bytes.push_back(8'h00);
                queued += frame_buf.size();
            end
            else
            begin
                cut = $urandom_range(1, 4);
                repeat (cut) pending_bytes.push_back(8'($urandom));
                queued += cut;
            end
        end
    endtask

    initial
    begin
        logic [3:0] plan [$];
        plan = '{4'd14, 4'd1, 4'd0, 4'd15, 4'd10};
        plan.push_back(4'($urandom_range(2, 13)));
        plan.push_back(4'($urandom_range(1, 14)));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed part at the reset channel count, no idling at first
        in_gap_max = 0;
        out_stall_max = 0;
        pending_bytes.push_back(8'h00);
        pending_bytes.push_back(8'hFF);
        pending_bytes.push_back(HDR_SECOND);
        fill_words(1);
        build_frame(1'b0, 0);
        queue_bytes(0, frame_buf.size());
        fill_words(0);
        build_frame(1'b1, 0);
        queue_bytes(0, frame_buf.size());
        wait_idle(0);
        in_gap_max = 5;
        out_stall_max = 5;
        fill_words(0);
        build_frame(1'b0, 2);
        queue_bytes(0, frame_buf.size());
        // sender holds mid frame until every word is out
        fill_words(0);
        build_frame(1'b0, 0);
        queue_bytes(0, 16);
        wait_idle(0);
        queue_bytes(16, frame_buf.size());

        set_channels(4'd0);
        fill_words(0);
        build_frame(1'b0, 0);
        queue_bytes(0, frame_buf.size());
        build_frame(1'b1, 0);
        queue_bytes(0, frame_buf.size());

        set_channels(4'd15);
        fill_words(1);
        build_frame(1'b0, 0);
        queue_bytes(0, frame_buf.size());

        // random part, one channel count per phase
        foreach (plan[p])
        begin
            set_channels(plan[p]);
            set_pace();
            queue_random_traffic(RAND_BYTES / plan.size());
        end

        wait_idle(SETTLE);
        if (err_cnt == 0)
            $display("[rc_serial_frame_channel_decoder_unit] OK");
        else
            $display("[rc_serial_frame_channel_decoder_unit] ERROR");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/rcfd_pkg.sv
rtl/rcfd_cmd_fifo.sv
rtl/rcfd_front.sv
rtl/rcfd_back.sv
rtl/rc_serial_frame_channel_decoder_unit.sv
verif/rc_serial_frame_channel_decoder_unit_tb.sv
